@@ rtl/core/path_canonicalizer_top_assert.svh @@
// Assertion macros shared by the path canonicalizer RTL.
// Each macro expands to one labeled concurrent assertion that is
// disabled while reset is held low.
`ifndef PATH_CANONICALIZER_TOP_ASSERT_SVH
`define PATH_CANONICALIZER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCAN_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PCAN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/pcan_pkg.sv @@
`default_nettype none

package pcan_pkg;

    localparam int PCAN_CAPACITY = 1024;
    localparam int OUT_LEN_W     = 10;

    localparam logic [7:0] SEP_CHAR = 8'h2F;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

    localparam logic [2:0] FN_CLEAR = 3'd0;
    localparam logic [2:0] FN_BASE  = 3'd1;
    localparam logic [2:0] FN_PATH  = 3'd2;
    localparam logic [2:0] FN_END   = 3'd3;
    localparam logic [2:0] FN_READ  = 3'd4;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic                 status;
        logic [7:0]           out_byte;
        logic                 out_last;
        logic [OUT_LEN_W-1:0] out_length;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic ack;
    } t_seq_ctrl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

endpackage

`default_nettype wire

@@ rtl/core/pcan_stream_if.sv @@
`default_nettype none

interface pcan_stream_if #(
    parameter type t_payload = logic [0:0]
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pcan_ram.sv @@
`default_nettype none

module pcan_ram import pcan_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = PCAN_CAPACITY
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/pcan_seq.sv @@
`default_nettype none
`include "path_canonicalizer_top_assert.svh"

module pcan_seq import pcan_pkg::*; #(
    parameter int PATH_CAPACITY = PCAN_CAPACITY
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_seq_ctrl i_ctrl,
    input  wire t_in_item  i_cmd,
    output t_seq_stat      o_stat,
    output t_out_item      o_result
);

    localparam int AW = $clog2(PATH_CAPACITY);
    localparam logic [AW-1:0] LEN_MAX = AW'(PATH_CAPACITY - 1);
    localparam logic [AW-1:0] LEN_ONE = AW'(1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_ENSEP   = 4'd2;
    localparam logic [3:0] S_PBODY   = 4'd3;
    localparam logic [3:0] S_PDOTS   = 4'd4;
    localparam logic [3:0] S_PCHAR   = 4'd5;
    localparam logic [3:0] S_POP     = 4'd6;
    localparam logic [3:0] S_SCAN    = 4'd7;
    localparam logic [3:0] S_SCHK    = 4'd8;
    localparam logic [3:0] S_REFRESH = 4'd9;
    localparam logic [3:0] S_RFCHK   = 4'd10;
    localparam logic [3:0] S_ECOMP   = 4'd11;
    localparam logic [3:0] S_EFIX    = 4'd12;
    localparam logic [3:0] S_RDATA   = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0]    r_state, n_state;
    logic [3:0]    r_ret, n_ret;
    logic [2:0]    r_func, n_func;
    logic [7:0]    r_byte, n_byte;
    logic [AW-1:0] r_len, n_len;
    logic [1:0]    r_clen, n_clen;
    logic [1:0]    r_dots, n_dots;
    logic          r_seen, n_seen;
    logic          r_bovf, n_bovf;
    logic          r_tlong, n_tlong;
    logic [AW-1:0] r_rp, n_rp;
    logic          r_last_sep, n_last_sep;
    logic [AW-1:0] r_k, n_k;
    logic [7:0]    r_obyte, n_obyte;
    logic          r_olast, n_olast;

    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [7:0]    w_mem_wdata;
    logic [AW-1:0] w_mem_raddr;
    logic [7:0]    w_mem_rdata;

    logic          w_put_ok;
    logic [AW-1:0] w_len_inc;
    logic [AW-1:0] w_len_dec;
    logic [AW-1:0] w_k_dec;
    logic [AW-1:0] w_rp_inc;
    logic          w_byte_sep;
    logic          w_byte_dot;
    logic          w_dotdot;

    pcan_ram #(
        .WIDTH (8),
        .DEPTH (PATH_CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // The length counter, the scan index and the read pointer each have their own
    // step unit; the store has one write port and one read port.
    assign w_put_ok   = (r_len < LEN_MAX);
    assign w_len_inc  = r_len + LEN_ONE;
    assign w_len_dec  = r_len - LEN_ONE;
    assign w_k_dec    = r_k - LEN_ONE;
    assign w_rp_inc   = r_rp + LEN_ONE;
    assign w_byte_sep = (r_byte == SEP_CHAR);
    assign w_byte_dot = (r_byte == DOT_CHAR);
    assign w_dotdot   = (r_clen == 2'd2) && (r_dots == 2'd2);

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_func     = r_func;
        n_byte     = r_byte;
        n_len      = r_len;
        n_clen     = r_clen;
        n_dots     = r_dots;
        n_seen     = r_seen;
        n_bovf     = r_bovf;
        n_tlong    = r_tlong;
        n_rp       = r_rp;
        n_last_sep = r_last_sep;
        n_k        = r_k;
        n_obyte    = r_obyte;
        n_olast    = r_olast;

        w_mem_we    = 1'b0;
        w_mem_waddr = r_len;
        w_mem_wdata = r_byte;
        w_mem_raddr = r_rp;

        unique case (r_state)
            S_IDLE: begin
                if (i_ctrl.start) begin
                    n_func  = i_cmd.func;
                    n_byte  = i_cmd.byte_value;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_obyte = '0;
                n_olast = 1'b0;
                n_state = S_DONE;
                unique case (r_func)
                    FN_CLEAR: begin
                        n_len   = '0;
                        n_clen  = '0;
                        n_dots  = '0;
                        n_seen  = 1'b0;
                        n_bovf  = 1'b0;
                        n_tlong = 1'b0;
                        n_rp    = '0;
                    end
                    FN_BASE: begin
                        if (!r_seen) begin
                            if (w_put_ok) begin
                                w_mem_we   = 1'b1;
                                n_len      = w_len_inc;
                                n_last_sep = w_byte_sep;
                            end else begin
                                n_bovf = 1'b1;
                            end
                        end
                    end
                    FN_PATH: begin
                        if (!r_seen) begin
                            n_seen = 1'b1;
                            // An absolute path throws the base away.
                            if (w_byte_sep) begin
                                w_mem_we    = 1'b1;
                                w_mem_waddr = '0;
                                w_mem_wdata = SEP_CHAR;
                                n_len       = LEN_ONE;
                                n_bovf      = 1'b0;
                                n_last_sep  = 1'b1;
                                n_state     = S_PBODY;
                            end else if (r_bovf) begin
                                n_tlong = 1'b1;
                            end else begin
                                n_ret   = S_PBODY;
                                n_state = S_ENSEP;
                            end
                        end else if (!r_tlong) begin
                            n_state = S_PBODY;
                        end
                    end
                    FN_END: begin
                        if (!r_seen) begin
                            n_seen = 1'b1;
                            if (r_bovf) begin
                                n_tlong = 1'b1;
                            end else begin
                                n_ret   = S_ECOMP;
                                n_state = S_ENSEP;
                            end
                        end else if (!r_tlong) begin
                            n_state = S_ECOMP;
                        end
                    end
                    FN_READ: begin
                        if (r_rp < r_len) begin
                            w_mem_raddr = r_rp;
                            n_state     = S_RDATA;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_ENSEP: begin
                n_state = r_ret;
                if ((r_len == '0) || !r_last_sep) begin
                    if (w_put_ok) begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = SEP_CHAR;
                        n_len       = w_len_inc;
                        n_last_sep  = 1'b1;
                    end else begin
                        n_tlong = 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_PBODY: begin
                priority if (w_byte_sep) begin
                    n_clen = '0;
                    n_dots = '0;
                    if (w_dotdot) begin
                        n_ret   = S_DONE;
                        n_state = S_POP;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (w_byte_dot && (r_clen < 2'd2) && (r_dots == r_clen)) begin
                    // Dots are held back until the component proves to be a name.
                    n_dots  = r_dots + 2'd1;
                    n_clen  = r_clen + 2'd1;
                    n_state = S_DONE;
                end else if (r_clen == r_dots) begin
                    n_ret   = S_PDOTS;
                    n_state = S_ENSEP;
                end else begin
                    n_state = S_PCHAR;
                end
            end
            S_PDOTS: begin
                if (r_dots != '0) begin
                    if (w_put_ok) begin
                        w_mem_we    = 1'b1;
                        w_mem_wdata = DOT_CHAR;
                        n_len       = w_len_inc;
                        n_last_sep  = 1'b0;
                        n_dots      = r_dots - 2'd1;
                    end else begin
                        n_tlong = 1'b1;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_PCHAR;
                end
            end
            S_PCHAR: begin
                n_state = S_DONE;
                if (w_put_ok) begin
                    w_mem_we   = 1'b1;
                    n_len      = w_len_inc;
                    n_last_sep = w_byte_sep;
                    if (r_clen != 2'd3) begin
                        n_clen = r_clen + 2'd1;
                    end
                end else begin
                    n_tlong = 1'b1;
                end
            end
            S_POP: begin
                if (r_len == '0) begin
                    n_state = r_ret;
                end else if (r_len == LEN_ONE) begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = '0;
                    w_mem_wdata = SEP_CHAR;
                    n_last_sep  = 1'b1;
                    n_state     = r_ret;
                end else begin
                    n_k     = r_last_sep ? w_len_dec : r_len;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_k == '0) begin
                    // No slash left at all: the result falls back to root.
                    w_mem_we    = 1'b1;
                    w_mem_waddr = '0;
                    w_mem_wdata = SEP_CHAR;
                    n_len       = LEN_ONE;
                    n_last_sep  = 1'b1;
                    n_state     = r_ret;
                end else begin
                    w_mem_raddr = w_k_dec;
                    n_state     = S_SCHK;
                end
            end
            S_SCHK: begin
                if (w_mem_rdata == SEP_CHAR) begin
                    if (r_k == LEN_ONE) begin
                        n_len      = LEN_ONE;
                        n_last_sep = 1'b1;
                        n_state    = r_ret;
                    end else begin
                        n_len   = w_k_dec;
                        n_state = S_REFRESH;
                    end
                end else begin
                    n_k     = w_k_dec;
                    n_state = S_SCAN;
                end
            end
            S_REFRESH: begin
                // The new last byte may be a slash copied in from the base.
                w_mem_raddr = w_len_dec;
                n_state     = S_RFCHK;
            end
            S_RFCHK: begin
                n_last_sep = (w_mem_rdata == SEP_CHAR);
                n_state    = r_ret;
            end
            S_ECOMP: begin
                n_clen = '0;
                n_dots = '0;
                if (w_dotdot) begin
                    n_ret   = S_EFIX;
                    n_state = S_POP;
                end else begin
                    n_state = S_EFIX;
                end
            end
            S_EFIX: begin
                n_rp    = '0;
                n_state = S_DONE;
                if (r_len == '0) begin
                    w_mem_we    = 1'b1;
                    w_mem_wdata = SEP_CHAR;
                    n_len       = LEN_ONE;
                    n_last_sep  = 1'b1;
                end else if ((r_len > LEN_ONE) && r_last_sep) begin
                    n_len   = w_len_dec;
                    n_ret   = S_DONE;
                    n_state = S_REFRESH;
                end
            end
            S_RDATA: begin
                n_obyte = w_mem_rdata;
                n_olast = (w_rp_inc == r_len);
                n_rp    = w_rp_inc;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_ctrl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_DONE;
            r_len   <= '0;
            r_clen  <= '0;
            r_dots  <= '0;
            r_seen  <= 1'b0;
            r_bovf  <= 1'b0;
            r_tlong <= 1'b0;
            r_rp    <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_len   <= n_len;
            r_clen  <= n_clen;
            r_dots  <= n_dots;
            r_seen  <= n_seen;
            r_bovf  <= n_bovf;
            r_tlong <= n_tlong;
            r_rp    <= n_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_byte     <= n_byte;
        r_last_sep <= n_last_sep;
        r_k        <= n_k;
        r_obyte    <= n_obyte;
        r_olast    <= n_olast;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);

    assign o_result.status     = r_tlong | r_bovf;
    assign o_result.out_byte   = r_obyte;
    assign o_result.out_last   = r_olast;
    assign o_result.out_length = OUT_LEN_W'(r_len);

    `PCAN_ASSERT_IMPLIES(a_tlong_after_seen, i_clk, i_rst_n, r_tlong, r_seen)
    `PCAN_ASSERT_IMPLIES(a_dots_within_comp, i_clk, i_rst_n, 1'b1, r_dots <= r_clen)
    `PCAN_ASSERT_IMPLIES(a_scan_in_range, i_clk, i_rst_n, (r_state == S_SCAN) || (r_state == S_SCHK), r_k <= r_len)
    `PCAN_ASSERT_IMPLIES(a_no_write_at_rest, i_clk, i_rst_n, w_mem_we, (r_state != S_IDLE) && (r_state != S_DONE))
    `PCAN_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, (r_state == S_DECODE) && (r_func == FN_CLEAR), (r_len == '0) && !r_seen && !r_tlong)

endmodule

`default_nettype wire

@@ rtl/core/path_canonicalizer_top.sv @@
// Path canonicalizer: after a clear (func 0) it takes working-directory bytes
// (func 1), then path bytes (func 2), then an end mark (func 3), and builds a
// canonical absolute path in an internal byte store; func 4 reads the result
// back one byte per transfer, with out_last on the final byte. Every input
// transfer yields exactly one output transfer carrying status, out_byte,
// out_last and the current length. One item is worked on at a time and the
// input is not ready until its result sits in the output register, so with the
// result side ready the next input transfer can share the edge of the result
// transfer. A path byte that starts a name first writes out any held-back
// dots ahead of it, and the first path byte of a relative path, or an end
// mark with no path byte before it, goes through a separator check. An end
// mark drops a trailing slash. A parent component scans back byte by byte to
// the previous slash and then re-checks the new last byte, since the store
// has one read port with a registered output. The store is not cleared after
// reset; only bytes written since the last clear or reset are ever read.
`default_nettype none

module path_canonicalizer_top import pcan_pkg::*; #(
    parameter int PATH_CAPACITY = PCAN_CAPACITY
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    pcan_stream_if.sink   i_in,
    pcan_stream_if.source o_out
);

    t_seq_ctrl w_ctrl;
    t_seq_stat w_stat;
    t_out_item w_result;
    t_in_item  w_cmd;

    logic      r_out_valid;
    t_out_item r_out_item;

    assign w_cmd        = i_in.payload;
    assign i_in.ready   = w_stat.idle;
    assign w_ctrl.start = i_in.valid && w_stat.idle;
    // A finished result moves into the output register once it is free.
    assign w_ctrl.ack   = w_stat.done && (!r_out_valid || o_out.ready);

    pcan_seq #(
        .PATH_CAPACITY (PATH_CAPACITY)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.ack) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.ack) begin
            r_out_item <= w_result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

endmodule

`default_nettype wire

@@ tb/path_canonicalizer_checker.sv @@
module path_canonicalizer_checker import pcan_pkg::*; #(
    parameter int PATH_CAPACITY = PCAN_CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_item,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_too_long_seen,
    output int                   o_bytes_read,
    output logic [OUT_LEN_W-1:0] o_path_length
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COMPONENT_MAX = 1023;
    localparam int MAX_REPORTS   = 10;

    // Shadow copy of the canonicalizer state.
    logic [7:0] path_bytes [PATH_CAPACITY];
    int         built_len;
    int         comp_chars;
    int         comp_dots;
    bit         path_started;
    bit         base_too_long;
    bit         name_too_long;
    int         read_index;

    t_out_item  expected_results [$];
    t_out_item  want;
    int         reports;

    assign o_path_length = OUT_LEN_W'(built_len);

    function automatic void clear_path();
        built_len     = 0;
        comp_chars    = 0;
        comp_dots     = 0;
        path_started  = 1'b0;
        base_too_long = 1'b0;
        name_too_long = 1'b0;
        read_index    = 0;
    endfunction

    function automatic bit append_byte(input logic [7:0] value);
        if (built_len >= PATH_CAPACITY - 1) begin
            name_too_long = 1'b1;
            return 1'b0;
        end
        path_bytes[built_len] = value;
        built_len++;
        return 1'b1;
    endfunction

    function automatic bit append_separator();
        if (built_len != 0 && path_bytes[built_len-1] == SEP_CHAR) begin
            return 1'b1;
        end
        return append_byte(SEP_CHAR);
    endfunction

    // A finished ".." component drops the last component; root stays root.
    function automatic void close_component();
        int k;
        if (comp_chars == 2 && comp_dots == 2 && built_len != 0) begin
            if (built_len == 1) begin
                path_bytes[0] = SEP_CHAR;
            end else begin
                if (path_bytes[built_len-1] == SEP_CHAR) begin
                    built_len--;
                end
                k = built_len;
                while (k > 0 && path_bytes[k-1] != SEP_CHAR) begin
                    k--;
                end
                if (k == 0) begin
                    path_bytes[0] = SEP_CHAR;
                    built_len = 1;
                end else if (k == 1) begin
                    built_len = 1;
                end else begin
                    built_len = k - 1;
                end
            end
        end
        comp_chars = 0;
        comp_dots  = 0;
    endfunction

    function automatic t_out_item canonical_result(input t_in_item item);
        t_out_item  result;
        logic [7:0] value;
        bit         ok;
        int         i;
        value           = item.byte_value;
        result.out_byte = '0;
        result.out_last = 1'b0;
        case (item.func)
            FN_CLEAR: begin
                clear_path();
            end
            FN_BASE: begin
                if (!path_started) begin
                    if (built_len >= PATH_CAPACITY - 1) begin
                        base_too_long = 1'b1;
                    end else begin
                        path_bytes[built_len] = value;
                        built_len++;
                    end
                end
            end
            FN_PATH: begin
                if (!path_started) begin
                    path_started = 1'b1;
                    if (value == SEP_CHAR) begin
                        path_bytes[0] = SEP_CHAR;
                        built_len     = 1;
                        base_too_long = 1'b0;
                    end else if (base_too_long) begin
                        name_too_long = 1'b1;
                    end else begin
                        void'(append_separator());
                    end
                end
                if (!name_too_long) begin
                    if (value == SEP_CHAR) begin
                        close_component();
                    end else if (value == DOT_CHAR && comp_chars < 2 &&
                                 comp_dots == comp_chars) begin
                        comp_dots++;
                        comp_chars++;
                    end else begin
                        ok = 1'b1;
                        // Dots held back so far turn out to be part of a name.
                        if (comp_chars == comp_dots) begin
                            ok = append_separator();
                            for (i = 0; i < comp_dots && ok; i++) begin
                                ok = append_byte(DOT_CHAR);
                            end
                            if (ok) begin
                                comp_dots = 0;
                            end
                        end
                        if (ok) begin
                            if (append_byte(value) && comp_chars < COMPONENT_MAX) begin
                                comp_chars++;
                            end
                        end
                    end
                end
            end
            FN_END: begin
                if (!path_started) begin
                    path_started = 1'b1;
                    if (base_too_long) begin
                        name_too_long = 1'b1;
                    end else begin
                        void'(append_separator());
                    end
                end
                if (!name_too_long) begin
                    close_component();
                    if (built_len == 0) begin
                        void'(append_byte(SEP_CHAR));
                    end
                    if (built_len > 1 && path_bytes[built_len-1] == SEP_CHAR) begin
                        built_len--;
                    end
                    read_index = 0;
                end
            end
            FN_READ: begin
                if (read_index < built_len) begin
                    result.out_byte = path_bytes[read_index];
                    result.out_last = (read_index + 1 == built_len);
                    read_index++;
                    o_bytes_read++;
                end
            end
            default: begin
            end
        endcase
        result.status     = name_too_long || base_too_long;
        result.out_length = OUT_LEN_W'(built_len);
        return result;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_path();
            expected_results.delete();
            o_fail_count    = 0;
            o_checked       = 0;
            o_too_long_seen = 0;
            o_bytes_read    = 0;
            reports         = 0;
        end else begin
            // No result can leave in the cycle its item enters, so the order is free.
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(canonical_result(i_in_item));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("%0t: unexpected result transfer: status %0d byte %02h",
                                 $realtime, i_out_item.status, i_out_item.out_byte);
                        $display("    last %0d length %0d",
                                 i_out_item.out_last, i_out_item.out_length);
                    end
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    if (i_out_item.status) begin
                        o_too_long_seen++;
                    end
                    if (i_out_item != want) begin
                        o_fail_count++;
                        if (reports < MAX_REPORTS) begin
                            reports++;
                            $display("%0t: result %0d mismatch", $realtime, o_checked);
                            $display("    expected status %0d byte %02h last %0d length %0d",
                                     want.status, want.out_byte, want.out_last, want.out_length);
                            $display("    actual   status %0d byte %02h last %0d length %0d",
                                     i_out_item.status, i_out_item.out_byte,
                                     i_out_item.out_last, i_out_item.out_length);
                        end
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pcan_pkg::*;

    localparam int         RANDOM_ITEMS    = 640;
    localparam int         STALL_LIMIT     = 12000;
    localparam int         SETTLE_CYCLES   = 20;
    localparam int         LONG_KINDS      = 4;
    localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FN_UNUSED_LAST  = 3'd7;
    localparam logic [7:0] LETTER_A        = 8'h61;

    logic i_clk;
    logic i_rst_n;

    pcan_stream_if #(.t_payload(t_in_item))  in_ch ();
    pcan_stream_if #(.t_payload(t_out_item)) out_ch ();

    int                   fail_count;
    int                   pending;
    int                   checked;
    int                   too_long_seen;
    int                   bytes_read;
    logic [OUT_LEN_W-1:0] path_length;

    int n_items;
    int n_sequences;
    int burst_left;
    int idle_cycles;
    int ready_phase;
    int stall_left;

    path_canonicalizer_top #(
        .PATH_CAPACITY(PCAN_CAPACITY)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    path_canonicalizer_checker #(
        .PATH_CAPACITY(PCAN_CAPACITY)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_ch.valid),
        .i_in_ready     (in_ch.ready),
        .i_in_item      (in_ch.payload),
        .i_out_valid    (out_ch.valid),
        .i_out_ready    (out_ch.ready),
        .i_out_item     (out_ch.payload),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_too_long_seen(too_long_seen),
        .o_bytes_read   (bytes_read),
        .o_path_length  (path_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The result side cycles through always ready, random, and bursty stalls.
    always @(negedge i_clk) begin
        ready_phase++;
        case ((ready_phase / 250) % 4)
            0: begin
                out_ch.ready <= 1'b1;
            end
            1: begin
                out_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                if (stall_left > 0) begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(1, 12);
                    end
                end
            end
            default: begin
                out_ch.ready <= 1'($urandom_range(0, 1));
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(input logic [2:0] func, input logic [7:0] value);
        t_in_item item;
        item.func       = func;
        item.byte_value = value;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= item;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        n_items++;
        @(negedge i_clk);
    endtask

    // Mostly lowercase letters, with an arbitrary byte now and then.
    task automatic send_name(input logic [2:0] func, input int length);
        repeat (length) begin
            if ($urandom_range(0, 15) == 0) begin
                send(func, rand_byte());
            end else begin
                send(func, LETTER_A + 8'($urandom_range(0, 25)));
            end
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic run_path_sequence();
        int n_parts;
        int k;
        int n_reads;
        send(FN_CLEAR, rand_byte());
        if ($urandom_range(0, 5) != 0) begin
            if ($urandom_range(0, 3) != 0) begin
                send(FN_BASE, SEP_CHAR);
            end
            n_parts = $urandom_range(1, 3);
            for (k = 0; k < n_parts; k++) begin
                send_name(FN_BASE, $urandom_range(1, 5));
                if (k + 1 < n_parts || $urandom_range(0, 2) == 0) begin
                    send(FN_BASE, SEP_CHAR);
                end
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            send(FN_PATH, SEP_CHAR);
        end
        n_parts = $urandom_range(0, 6);
        for (k = 0; k < n_parts; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 2))
                    0: send(FN_BASE, rand_byte());
                    1: send(3'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST)), rand_byte());
                    default: send(FN_READ, rand_byte());
                endcase
            end
            case ($urandom_range(0, 9))
                0: begin
                    send(FN_PATH, DOT_CHAR);
                end
                1, 2: begin
                    send(FN_PATH, DOT_CHAR);
                    send(FN_PATH, DOT_CHAR);
                end
                3: begin
                    repeat (3) send(FN_PATH, DOT_CHAR);
                end
                4: begin
                    send(FN_PATH, DOT_CHAR);
                    send_name(FN_PATH, $urandom_range(1, 3));
                end
                5: begin
                    send_name(FN_PATH, $urandom_range(1, 3));
                    send(FN_PATH, DOT_CHAR);
                end
                default: begin
                    send_name(FN_PATH, $urandom_range(1, 6));
                end
            endcase
            if (k + 1 < n_parts || $urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 2)) send(FN_PATH, SEP_CHAR);
            end
        end
        // A few sequences skip the end mark or keep going after it.
        if ($urandom_range(0, 14) != 0) begin
            send(FN_END, rand_byte());
        end
        if ($urandom_range(0, 9) == 0) begin
            send_name(FN_PATH, $urandom_range(1, 3));
            send(FN_END, rand_byte());
        end
        n_reads = path_length + $urandom_range(0, 1);
        if ($urandom_range(0, 4) == 0) begin
            n_reads = $urandom_range(0, n_reads + 2);
        end
        repeat (n_reads) send(FN_READ, rand_byte());
        n_sequences++;
    endtask

    task automatic run_long_sequence(input int kind);
        int k;
        send(FN_CLEAR, rand_byte());
        // One byte more than the store holds pushes the base over capacity.
        if (kind < 2) begin
            for (k = 0; k < PCAN_CAPACITY + 1; k++) begin
                send(FN_BASE, (k % 16 == 0) ? SEP_CHAR : LETTER_A + 8'(k % 26));
            end
        end else begin
            send(FN_BASE, SEP_CHAR);
        end
        case (kind)
            0: begin
                send_name(FN_PATH, 3);
                send(FN_PATH, SEP_CHAR);
                send_name(FN_PATH, 2);
            end
            1: begin
                send(FN_PATH, SEP_CHAR);
                send_name(FN_PATH, 2);
                send(FN_PATH, SEP_CHAR);
                send(FN_PATH, DOT_CHAR);
                send(FN_PATH, DOT_CHAR);
                send(FN_PATH, SEP_CHAR);
                send_name(FN_PATH, 2);
            end
            2: begin
                send_name(FN_PATH, PCAN_CAPACITY + 2);
                send(FN_PATH, SEP_CHAR);
                send(FN_PATH, DOT_CHAR);
                send(FN_PATH, DOT_CHAR);
            end
            default: begin
                // A parent step right below capacity scans back a whole store.
                send_name(FN_PATH, PCAN_CAPACITY - 3);
                send(FN_PATH, SEP_CHAR);
                send(FN_PATH, DOT_CHAR);
                send(FN_PATH, DOT_CHAR);
                send(FN_PATH, SEP_CHAR);
                send_name(FN_PATH, 2);
            end
        endcase
        send(FN_END, rand_byte());
        repeat (4) send(FN_READ, rand_byte());
        n_sequences++;
    endtask

    initial begin : stimulus
        int f;
        int random_items;
        int items_before;
        int long_done;
        int long_kind;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        i_rst_n       = 1'b0;
        n_items       = 0;
        n_sequences   = 0;
        burst_left    = 0;
        idle_cycles   = 0;
        ready_phase   = 0;
        stall_left    = 0;
        random_items  = 0;
        long_done     = 0;
        long_kind     = $urandom_range(0, LONG_KINDS - 1);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Read with nothing built, then a relative path on an empty base.
        send(FN_READ, 8'hFF);
        send(FN_CLEAR, 8'h00);
        send(FN_PATH, DOT_CHAR);
        send(FN_PATH, DOT_CHAR);
        send(FN_PATH, SEP_CHAR);
        send(FN_PATH, 8'hFF);
        send(FN_BASE, LETTER_A);
        send(FN_END, 8'h55);
        repeat (3) send(FN_READ, 8'h00);
        send(FN_PATH, 8'h00);
        send(FN_END, 8'hAA);
        send(FN_READ, 8'h7F);
        for (f = FN_UNUSED_FIRST; f <= FN_UNUSED_LAST; f++) begin
            send(3'(f), rand_byte());
        end
        // Empty path: the result is the base without its trailing slash.
        send(FN_CLEAR, 8'hFF);
        send(FN_BASE, SEP_CHAR);
        send(FN_BASE, LETTER_A + 8'd16);
        send(FN_BASE, SEP_CHAR);
        send(FN_END, 8'h00);
        repeat (3) send(FN_READ, 8'hFF);

        while (random_items < RANDOM_ITEMS) begin
            // When run here, the one capacity sequence starts with nothing in flight.
            if (long_done == 0 && n_sequences % 8 == 7) begin
                wait_drained();
                run_long_sequence(long_kind);
                long_done = 1;
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end
            items_before = n_items;
            run_path_sequence();
            random_items += n_items - items_before;
        end
        if (long_done == 0) begin
            run_long_sequence(long_kind);
            long_done = 1;
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Sent %0d input transfers in %0d path sequences, one run at store capacity.",
                 n_items, n_sequences);
        $display("Checked %0d results: %0d path bytes read back, %0d with name-too-long status.",
                 checked, bytes_read, too_long_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
